@@ src/bnil_pkg.sv @@
// Shared types and constants for the bidirectional name index lookup.
// Used by the front, back, top level and checker; no dependencies.
package bnil_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_NAME_LEN    = 20;

    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int NUM_W  = 11;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic REPLY_NAME   = 1'b0;
    localparam logic REPLY_NUMBER = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_NUMBER,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [NUM_W-1:0]  num;
    } cmd_t;

endpackage

@@ src/bnil_front.sv @@
// Input side: accepts items, drops unused kinds, and queues commands.
// Depends on bnil_pkg for the command type and kind codes.
module bnil_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bnil_pkg::KIND_W-1:0]    kind,
    input  logic [bnil_pkg::CHAR_W-1:0]    char_code,
    input  logic                           last_char,
    input  logic [bnil_pkg::NUM_W-1:0]     entry_number,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output bnil_pkg::cmd_t                 cmd
);

    localparam int QD  = 4;
    localparam int QAW = 2;
    localparam int QCW = 3;

    bnil_pkg::cmd_t q_mem [QD];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] cnt_reg;

    bnil_pkg::cmd_t cls;
    logic           keep;
    logic           push, pop;

    always_comb
    begin
        keep     = 1'b1;
        cls.ch   = char_code;
        cls.last = last_char;
        cls.num  = entry_number;
        cls.op   = bnil_pkg::OP_LOAD;
        unique case (kind)
            bnil_pkg::KIND_LOAD:   cls.op = bnil_pkg::OP_LOAD;
            bnil_pkg::KIND_NUMBER: cls.op = bnil_pkg::OP_NUMBER;
            bnil_pkg::KIND_QUERY:  cls.op = bnil_pkg::OP_QUERY;
            default:               keep = 1'b0;
        endcase
    end

    assign in_ready  = (cnt_reg != QCW'(QD));
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCW'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCW'(1);
        end
    end

endmodule

@@ src/bnil_back.sv @@
// Execution side: name table, sorted index, binary search and reply register.
// Depends on bnil_pkg; takes commands from bnil_front.
module bnil_back #(
    parameter int MAX_ENTRIES = bnil_pkg::DEF_MAX_ENTRIES,
    parameter int NAME_LEN    = bnil_pkg::DEF_NAME_LEN
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  bnil_pkg::cmd_t               cmd,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         reply_kind,
    output logic [bnil_pkg::CHAR_W-1:0]  out_char,
    output logic                         out_last,
    output logic                         found,
    output logic [bnil_pkg::NUM_W-1:0]   number_out
);

    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = $clog2(NAME_LEN + 1);
    localparam int PW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
    localparam int AW = EW + PW;
    localparam int SD = MAX_ENTRIES * (2 ** PW);
    localparam int NW = (CW > bnil_pkg::NUM_W) ? CW : bnil_pkg::NUM_W;
    localparam int CH = bnil_pkg::CHAR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_CMP,
        S_REPLY,
        S_NAME,
        S_SHR,
        S_SHW
    } state_t;

    // storage
    logic [CH-1:0] name_mem [SD];
    logic [LW-1:0] len_mem  [MAX_ENTRIES];
    logic [EW-1:0] sort_mem [MAX_ENTRIES];
    logic [CH-1:0] lbuf_reg [NAME_LEN];
    logic [CH-1:0] qbuf_reg [NAME_LEN];
    logic [CH-1:0] name_rdata_reg;
    logic [LW-1:0] len_rdata_reg;
    logic [EW-1:0] sort_rdata_reg;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] lpos_reg, lpos_next, qlen_reg, qlen_next;
    logic [LW-1:0] blen_reg, blen_next;
    logic          bsel_reg, bsel_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next, j_reg, j_next;
    logic [EW-1:0] e_reg, e_next;
    logic [LW-1:0] i_reg, i_next;
    logic          pkind_reg, pkind_next, pfound_reg, pfound_next;
    logic [bnil_pkg::NUM_W-1:0] pnum_reg, pnum_next;
    logic          ov_reg, ov_next, okind_reg, okind_next, olast_reg, olast_next;
    logic          ofound_reg, ofound_next;
    logic [CH-1:0] ochar_reg, ochar_next;
    logic [bnil_pkg::NUM_W-1:0] onum_reg, onum_next;

    logic          name_we, len_we, sort_we, lbuf_we, qbuf_we;
    logic [AW-1:0] name_waddr, name_raddr;
    logic [EW-1:0] sort_waddr, sort_raddr;
    logic [EW-1:0] sort_wdata;
    logic [LW-1:0] lpos_inc, qlen_inc;
    logic [NW-1:0] numx;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] j_m1;
    logic [CH-1:0] bch;
    logic          slot_free, probe, done, lt, gt;

    assign lpos_inc = (lpos_reg < LW'(NAME_LEN)) ? lpos_reg + LW'(1) : lpos_reg;
    assign qlen_inc = (qlen_reg < LW'(NAME_LEN)) ? qlen_reg + LW'(1) : qlen_reg;
    assign numx     = NW'(cmd.num);
    assign j_m1     = j_reg - CW'(1);
    assign bch      = bsel_reg ? qbuf_reg[i_reg[PW-1:0]] : lbuf_reg[i_reg[PW-1:0]];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lpos_next   = lpos_reg;
        qlen_next   = qlen_reg;
        blen_next   = blen_reg;
        bsel_next   = bsel_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        j_next      = j_reg;
        e_next      = e_reg;
        i_next      = i_reg;
        pkind_next  = pkind_reg;
        pfound_next = pfound_reg;
        pnum_next   = pnum_reg;
        okind_next  = okind_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        ofound_next = ofound_reg;
        onum_next   = onum_reg;
        cmd_ready   = 1'b0;
        name_we     = 1'b0;
        len_we      = 1'b0;
        sort_we     = 1'b0;
        lbuf_we     = 1'b0;
        qbuf_we     = 1'b0;
        name_waddr  = {count_reg[EW-1:0], lpos_reg[PW-1:0]};
        sort_waddr  = j_reg[EW-1:0];
        sort_wdata  = sort_rdata_reg;
        probe       = 1'b0;
        done        = 1'b0;
        lt          = 1'b0;
        gt          = 1'b0;
        slot_free   = !ov_reg || out_ready;
        ov_next     = ov_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        bnil_pkg::OP_LOAD:
                        begin
                            // drop loads once the table is full
                            if (count_reg != CW'(MAX_ENTRIES))
                            begin
                                if (lpos_reg < LW'(NAME_LEN))
                                begin
                                    name_we = 1'b1;
                                    lbuf_we = 1'b1;
                                end
                                lpos_next = lpos_inc;
                                if (cmd.last)
                                begin
                                    len_we    = 1'b1;
                                    blen_next = lpos_inc;
                                    bsel_next = 1'b0;
                                    lpos_next = '0;
                                    lo_next   = '0;
                                    hi_next   = count_reg;
                                    probe     = 1'b1;
                                end
                            end
                        end
                        bnil_pkg::OP_QUERY:
                        begin
                            if (qlen_reg < LW'(NAME_LEN))
                                qbuf_we = 1'b1;
                            qlen_next = qlen_inc;
                            if (cmd.last)
                            begin
                                blen_next = qlen_inc;
                                bsel_next = 1'b1;
                                qlen_next = '0;
                                lo_next   = '0;
                                hi_next   = count_reg;
                                probe     = 1'b1;
                            end
                        end
                        bnil_pkg::OP_NUMBER:
                        begin
                            if (numx == '0 || numx > NW'(count_reg))
                            begin
                                pkind_next  = bnil_pkg::REPLY_NAME;
                                pfound_next = 1'b0;
                                pnum_next   = '0;
                                state_next  = S_REPLY;
                            end
                            else
                            begin
                                e_next     = EW'(numx - NW'(1));
                                i_next     = '0;
                                state_next = S_NAME;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MID:
            begin
                e_next     = sort_rdata_reg;
                i_next     = '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (i_reg == len_rdata_reg || i_reg == blen_reg)
                begin
                    done = 1'b1;
                    lt   = len_rdata_reg < blen_reg;
                    gt   = len_rdata_reg > blen_reg;
                end
                else if (name_rdata_reg != bch)
                begin
                    done = 1'b1;
                    lt   = name_rdata_reg < bch;
                    gt   = !lt;
                end
                else
                    i_next = i_reg + LW'(1);
                if (done)
                begin
                    if (bsel_reg && !lt && !gt)
                    begin
                        pkind_next  = bnil_pkg::REPLY_NUMBER;
                        pfound_next = 1'b1;
                        pnum_next   = bnil_pkg::NUM_W'(CW'(e_reg) + CW'(1));
                        state_next  = S_REPLY;
                    end
                    else
                    begin
                        // equal names sort after, so only greater narrows from above
                        if (gt)
                            hi_next = mid_reg;
                        else
                            lo_next = mid_reg + CW'(1);
                        probe = 1'b1;
                    end
                end
            end
            S_REPLY:
            begin
                if (slot_free)
                begin
                    ov_next     = 1'b1;
                    okind_next  = pkind_reg;
                    ochar_next  = '0;
                    olast_next  = 1'b1;
                    ofound_next = pfound_reg;
                    onum_next   = pnum_reg;
                    state_next  = S_IDLE;
                end
            end
            S_NAME:
            begin
                if (slot_free)
                begin
                    ov_next     = 1'b1;
                    okind_next  = bnil_pkg::REPLY_NAME;
                    ochar_next  = name_rdata_reg;
                    olast_next  = (i_reg + LW'(1) == len_rdata_reg);
                    ofound_next = 1'b1;
                    onum_next   = '0;
                    i_next      = i_reg + LW'(1);
                    if (i_reg + LW'(1) == len_rdata_reg)
                        state_next = S_IDLE;
                end
            end
            S_SHR:
            begin
                if (j_reg == lo_reg)
                begin
                    sort_we    = 1'b1;
                    sort_waddr = lo_reg[EW-1:0];
                    sort_wdata = count_reg[EW-1:0];
                    count_next = count_reg + CW'(1);
                    state_next = S_IDLE;
                end
                else
                    state_next = S_SHW;
            end
            S_SHW:
            begin
                sort_we    = 1'b1;
                j_next     = j_m1;
                state_next = S_SHR;
            end
            default:
                state_next = S_IDLE;
        endcase

        // next probe of the search, or its end
        mid_sum = {1'b0, lo_next} + {1'b0, hi_next} - (CW + 1)'(1);
        if (probe)
        begin
            if (lo_next < hi_next)
            begin
                mid_next   = CW'(mid_sum >> 1);
                state_next = S_MID;
            end
            else if (bsel_next)
            begin
                pkind_next  = bnil_pkg::REPLY_NUMBER;
                pfound_next = 1'b0;
                pnum_next   = '0;
                state_next  = S_REPLY;
            end
            else
            begin
                j_next     = count_reg;
                state_next = S_SHR;
            end
        end

        sort_raddr = (state_reg == S_SHR) ? j_m1[EW-1:0] : mid_next[EW-1:0];
        name_raddr = {e_next, i_next[PW-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
            name_mem[name_waddr] <= cmd.ch;
        name_rdata_reg <= name_mem[name_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[count_reg[EW-1:0]] <= lpos_inc;
        len_rdata_reg <= len_mem[e_next];
    end

    always_ff @(posedge clk)
    begin
        if (sort_we)
            sort_mem[sort_waddr] <= sort_wdata;
        sort_rdata_reg <= sort_mem[sort_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lbuf_we)
            lbuf_reg[lpos_reg[PW-1:0]] <= cmd.ch;
        if (qbuf_we)
            qbuf_reg[qlen_reg[PW-1:0]] <= cmd.ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            lpos_reg   <= '0;
            qlen_reg   <= '0;
            blen_reg   <= '0;
            bsel_reg   <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            j_reg      <= '0;
            e_reg      <= '0;
            i_reg      <= '0;
            pkind_reg  <= 1'b0;
            pfound_reg <= 1'b0;
            pnum_reg   <= '0;
            ov_reg     <= 1'b0;
            okind_reg  <= 1'b0;
            ochar_reg  <= '0;
            olast_reg  <= 1'b0;
            ofound_reg <= 1'b0;
            onum_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            lpos_reg   <= lpos_next;
            qlen_reg   <= qlen_next;
            blen_reg   <= blen_next;
            bsel_reg   <= bsel_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            mid_reg    <= mid_next;
            j_reg      <= j_next;
            e_reg      <= e_next;
            i_reg      <= i_next;
            pkind_reg  <= pkind_next;
            pfound_reg <= pfound_next;
            pnum_reg   <= pnum_next;
            ov_reg     <= ov_next;
            okind_reg  <= okind_next;
            ochar_reg  <= ochar_next;
            olast_reg  <= olast_next;
            ofound_reg <= ofound_next;
            onum_reg   <= onum_next;
        end
    end

    assign out_valid  = ov_reg;
    assign reply_kind = okind_reg;
    assign out_char   = ochar_reg;
    assign out_last   = olast_reg;
    assign found      = ofound_reg;
    assign number_out = onum_reg;

endmodule

@@ src/bidirectional_name_index_lookup.sv @@
// Top level of the bidirectional name index lookup.
// Depends on bnil_pkg, bnil_front and bnil_back.
//
// Input channel (in_valid/in_ready): kind 0 loads one name character,
// kind 1 asks for the name of an entry number, kind 2 sends one character
// of a name query; last_char closes a load or query. Kind 3 is dropped.
// Output channel (out_valid/out_ready): name replies come as a run of
// characters with out_last on the final one; query replies are one item
// with the entry number. Misses give one item with found low.
// A four-deep command queue separates intake from execution, so items keep
// being taken while the engine works or the receiver stalls, until the queue is full.
// In the engine, a plain character is taken straight from idle; a number
// lookup sends the stored name one character per reply item. A query runs
// about ceil(log2(count+1)) binary search probes, each reading the sorted
// index and comparing characters through the one-port name memory. A
// completed load runs the same search, then shifts up each index entry after it.
// Reset empties the table and the queue; no clearing pass is needed.
// A stalled receiver holds the output register and the engine waits on it.
module bidirectional_name_index_lookup #(
    parameter int MAX_ENTRIES = bnil_pkg::DEF_MAX_ENTRIES,
    parameter int NAME_LEN    = bnil_pkg::DEF_NAME_LEN
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bnil_pkg::KIND_W-1:0]  kind,
    input  logic [bnil_pkg::CHAR_W-1:0]  char_code,
    input  logic                         last_char,
    input  logic [bnil_pkg::NUM_W-1:0]   entry_number,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         reply_kind,
    output logic [bnil_pkg::CHAR_W-1:0]  out_char,
    output logic                         out_last,
    output logic                         found,
    output logic [bnil_pkg::NUM_W-1:0]   number_out
);

    logic           cmd_valid, cmd_ready;
    bnil_pkg::cmd_t cmd;

    bnil_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .char_code    (char_code),
        .last_char    (last_char),
        .entry_number (entry_number),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    bnil_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NAME_LEN    (NAME_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reply_kind (reply_kind),
        .out_char   (out_char),
        .out_last   (out_last),
        .found      (found),
        .number_out (number_out)
    );

endmodule

@@ src/bnil_checker.sv @@
// Port-level checks for the bidirectional name index lookup, bound to the top.
// Depends on bnil_pkg for field widths and reply codes.
module bnil_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         reply_kind,
    input logic [bnil_pkg::CHAR_W-1:0]  out_char,
    input logic                         out_last,
    input logic                         found,
    input logic [bnil_pkg::NUM_W-1:0]   number_out
);

    // hold a stalled reply
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last)
            && $stable(number_out) && $stable(reply_kind) && $stable(found))
        else $error("stalled reply changed");

    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("reply during reset");

    a_num_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind == bnil_pkg::REPLY_NUMBER |-> out_last && out_char == '0)
        else $error("number reply not a single item");

    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> out_last && number_out == '0 && out_char == '0)
        else $error("miss reply malformed");

    a_name_num: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind == bnil_pkg::REPLY_NAME |-> number_out == '0)
        else $error("name reply carries a number");

endmodule

bind bidirectional_name_index_lookup bnil_checker u_checker (.*);
